[rtl/lls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lift motion scheduler package
// Shared types, codes and frame tables of the lift bus scheduler.
// ----------------------------------------------------------------------------
package lls_pkg;

	localparam int SLOTS_PER_CYCLE_DEF = 20;
	localparam int SLOT_W = 5;
	localparam int POS_W = 16;
	localparam int MARGIN_W = 12;
	localparam int DCYC_W = 4;
	localparam int CFG_W = 12;

	localparam logic [SLOT_W-1:0] COMMAND_SLOT = 5'd10;
	localparam logic [SLOT_W-1:0] OCCUPIED_SLOTS = 5'd11;

	// Action codes
	localparam logic ACT_SET_TARGET = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Configuration register indexes
	localparam logic CFG_GOAL_OFFSET = 1'b0;
	localparam logic CFG_DECEL_CYCLES = 1'b1;

	localparam logic [MARGIN_W-1:0] GOAL_OFFSET_RST = 12'd108;
	localparam logic [DCYC_W-1:0] DECEL_CYCLES_RST = 4'd3;

	// Frame identifiers
	localparam logic [5:0] ID_ZERO_TX = 6'h11;
	localparam logic [5:0] ID_LEG_A = 6'h08;
	localparam logic [5:0] ID_LEG_B = 6'h09;
	localparam logic [5:0] ID_IDLE = 6'h10;
	localparam logic [5:0] ID_SLOT9 = 6'h01;
	localparam logic [5:0] ID_COMMAND = 6'h12;

	// Command codes
	localparam logic [7:0] CMD_AFTER_SCAN = 8'h50;
	localparam logic [7:0] CMD_STOP = 8'hfc;
	localparam logic [7:0] CMD_PRE_MOVE = 8'h49;
	localparam logic [7:0] CMD_PRE_STOP = 8'hcf;
	localparam logic [7:0] CMD_CLICK = 8'h0d;
	localparam logic [7:0] CMD_UP_ERR = 8'h8b;
	localparam logic [7:0] CMD_UP = 8'hca;
	localparam logic [7:0] CMD_DOWN_ERR = 8'h4c;
	localparam logic [7:0] CMD_DOWN = 8'h0d;
	localparam logic [7:0] CMD_DECEL = 8'h8e;
	localparam logic [POS_W-1:0] POS_AFTER_SCAN = 16'hfff6;

	typedef enum logic [1:0] {
		TG_STOP  = 2'd0,
		TG_UP    = 2'd1,
		TG_DOWN  = 2'd2,
		TG_CLICK = 2'd3
	} target_t;

	typedef enum logic [3:0] {
		MS_AFTER_SCAN = 4'd0,
		MS_STOP       = 4'd1,
		MS_PRE_MOVE   = 4'd2,
		MS_UP         = 4'd3,
		MS_DOWN       = 4'd4,
		MS_UP_DECEL   = 4'd5,
		MS_DOWN_DECEL = 4'd6,
		MS_PRE_STOP   = 4'd7,
		MS_CLICK      = 4'd8
	} motion_state_t;

	typedef struct packed {
		logic              action;
		logic [1:0]        target_request;
		logic signed [15:0] leg_a_position;
		logic signed [15:0] leg_b_position;
		logic              bus_busy;
	} in_item_t;

	typedef struct packed {
		logic              frame_start;
		logic [5:0]        frame_id;
		logic [1:0]        byte_count;
		logic              is_transmit;
		logic              abort_frame;
		logic signed [15:0] payload_position;
		logic [7:0]        payload_command;
		logic              report_valid;
		logic signed [15:0] reported_position;
	} out_item_t;

	// Per-tick slot decode handed from the scheduler to the rest of the block.
	typedef struct packed {
		logic       frame_start;
		logic [5:0] frame_id;
		logic [1:0] byte_count;
		logic       is_transmit;
		logic       abort_frame;
		logic       cmd_slot;
		logic       end_cycle;
	} slot_info_t;

	typedef struct packed {
		logic set_target;
		logic cmd_slot;
		logic end_cycle;
	} motion_ctl_t;

	function automatic logic [5:0] frame_id_of(input logic [SLOT_W-1:0] slot);
		logic [5:0] id;
		unique case (slot)
			5'd0: id = ID_ZERO_TX;
			5'd1: id = ID_LEG_A;
			5'd2: id = ID_LEG_B;
			5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8: id = ID_IDLE;
			5'd9: id = ID_SLOT9;
			5'd10: id = ID_COMMAND;
			default: id = 6'd0;
		endcase
		return id;
	endfunction

	function automatic logic [1:0] byte_count_of(input logic [SLOT_W-1:0] slot);
		logic [1:0] cnt;
		unique case (slot)
			5'd0, 5'd1, 5'd2, 5'd10: cnt = 2'd3;
			default: cnt = 2'd0;
		endcase
		return cnt;
	endfunction

endpackage
`default_nettype wire

[rtl/lls_slot_sched.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot scheduler
// Holds the slot index and decodes the frame started by each slot tick.
// ----------------------------------------------------------------------------
module lls_slot_sched #(
	parameter int SLOTS_PER_CYCLE = lls_pkg::SLOTS_PER_CYCLE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               tick,
	input  wire logic               bus_busy,
	output lls_pkg::slot_info_t     info
);

	localparam logic [lls_pkg::SLOT_W:0] LAST_LIMIT = (lls_pkg::SLOT_W+1)'(SLOTS_PER_CYCLE);

	logic [lls_pkg::SLOT_W-1:0] slot_q;
	logic [lls_pkg::SLOT_W:0]   slot_inc;
	logic                       occupied;
	logic                       end_cycle;

	assign occupied = slot_q < lls_pkg::OCCUPIED_SLOTS;
	assign slot_inc = {1'b0, slot_q} + 1'b1;
	assign end_cycle = slot_inc >= LAST_LIMIT;

	always_comb begin
		info.frame_start = occupied;
		info.frame_id = lls_pkg::frame_id_of(slot_q);
		info.byte_count = lls_pkg::byte_count_of(slot_q);
		info.is_transmit = (slot_q == '0) || (slot_q == lls_pkg::COMMAND_SLOT);
		// The previous slot was occupied when this one is 1 through 11.
		info.abort_frame = bus_busy && (slot_q != '0) && (slot_q <= lls_pkg::OCCUPIED_SLOTS);
		info.cmd_slot = tick && (slot_q == lls_pkg::COMMAND_SLOT);
		info.end_cycle = tick && end_cycle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (tick) begin
			slot_q <= end_cycle ? '0 : slot_inc[lls_pkg::SLOT_W-1:0];
		end
	end

endmodule
`default_nettype wire

[rtl/lls_motion.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motion state machine
// Builds the command word in the command slot and steps at cycle end.
// ----------------------------------------------------------------------------
module lls_motion (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lls_pkg::motion_ctl_t         ctl,
	input  wire logic [1:0]                   target_request,
	input  wire logic signed [15:0]           leg_a_position,
	input  wire logic signed [15:0]           leg_b_position,
	input  wire logic [lls_pkg::MARGIN_W-1:0] goal_offset,
	input  wire logic [lls_pkg::DCYC_W-1:0]   decel_cycles,
	output logic [lls_pkg::POS_W-1:0]         cmd_position,
	output logic [7:0]                        cmd_code
);

	lls_pkg::motion_state_t     state_q, state_d;
	lls_pkg::target_t           target_q, target_d;
	logic [lls_pkg::DCYC_W-1:0] count_q, count_d, count_inc;
	logic [lls_pkg::POS_W-1:0]  goal_q, goal_d;
	logic [lls_pkg::POS_W-1:0]  pos_q;
	logic [7:0]                 code_q;
	logic signed [15:0]         lo, hi;
	logic [lls_pkg::POS_W-1:0]  lo_u, hi_u, margin_ext;
	logic                       err;

	assign lo = (leg_a_position < leg_b_position) ? leg_a_position : leg_b_position;
	assign hi = (leg_a_position > leg_b_position) ? leg_a_position : leg_b_position;
	assign lo_u = lo;
	assign hi_u = hi;
	assign err = leg_a_position[15] | leg_b_position[15];
	assign margin_ext = {{(lls_pkg::POS_W-lls_pkg::MARGIN_W){1'b0}}, goal_offset};
	assign count_inc = count_q + 1'b1;

	always_comb begin
		state_d = state_q;
		target_d = target_q;
		count_d = count_q;
		goal_d = goal_q;
		cmd_position = pos_q;
		cmd_code = code_q;

		if (ctl.set_target) begin
			target_d = lls_pkg::target_t'(target_request);
		end

		if (ctl.cmd_slot) begin
			unique case (state_q)
				lls_pkg::MS_AFTER_SCAN: begin
					cmd_position = lls_pkg::POS_AFTER_SCAN;
					cmd_code = lls_pkg::CMD_AFTER_SCAN;
				end
				lls_pkg::MS_UP_DECEL: begin
					if (count_q == '0) begin
						goal_d = hi_u + margin_ext;
					end
					cmd_position = goal_d;
					cmd_code = lls_pkg::CMD_DECEL;
				end
				lls_pkg::MS_DOWN_DECEL: begin
					if (count_q == '0) begin
						goal_d = lo_u - margin_ext;
					end
					cmd_position = goal_d;
					cmd_code = lls_pkg::CMD_DECEL;
				end
				lls_pkg::MS_UP: begin
					cmd_position = err ? hi_u : lo_u;
					cmd_code = err ? lls_pkg::CMD_UP_ERR : lls_pkg::CMD_UP;
				end
				lls_pkg::MS_DOWN: begin
					cmd_position = err ? '0 : hi_u;
					cmd_code = err ? lls_pkg::CMD_DOWN_ERR : lls_pkg::CMD_DOWN;
				end
				lls_pkg::MS_PRE_MOVE: begin
					cmd_position = hi_u;
					cmd_code = lls_pkg::CMD_PRE_MOVE;
				end
				lls_pkg::MS_PRE_STOP: begin
					cmd_position = hi_u;
					cmd_code = lls_pkg::CMD_PRE_STOP;
				end
				lls_pkg::MS_CLICK: begin
					cmd_position = hi_u;
					cmd_code = lls_pkg::CMD_CLICK;
				end
				default: begin
					cmd_position = hi_u;
					cmd_code = lls_pkg::CMD_STOP;
				end
			endcase
		end

		if (ctl.end_cycle) begin
			unique case (state_q)
				lls_pkg::MS_AFTER_SCAN: state_d = lls_pkg::MS_STOP;
				lls_pkg::MS_PRE_MOVE: begin
					if (target_q == lls_pkg::TG_UP) state_d = lls_pkg::MS_UP;
					else if (target_q == lls_pkg::TG_DOWN) state_d = lls_pkg::MS_DOWN;
					else if (target_q == lls_pkg::TG_CLICK) state_d = lls_pkg::MS_CLICK;
				end
				lls_pkg::MS_UP: begin
					if (target_q != lls_pkg::TG_UP) begin
						state_d = lls_pkg::MS_UP_DECEL;
						count_d = '0;
					end
				end
				lls_pkg::MS_DOWN: begin
					if (target_q != lls_pkg::TG_DOWN) begin
						state_d = lls_pkg::MS_DOWN_DECEL;
						count_d = '0;
					end
				end
				lls_pkg::MS_UP_DECEL, lls_pkg::MS_DOWN_DECEL: begin
					count_d = count_inc;
					if (count_inc >= decel_cycles) state_d = lls_pkg::MS_PRE_STOP;
				end
				lls_pkg::MS_PRE_STOP: state_d = lls_pkg::MS_STOP;
				lls_pkg::MS_CLICK: begin
					state_d = lls_pkg::MS_PRE_STOP;
					target_d = lls_pkg::TG_STOP;
				end
				default: begin
					state_d = (target_q != lls_pkg::TG_STOP) ? lls_pkg::MS_PRE_MOVE
						: lls_pkg::MS_STOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lls_pkg::MS_AFTER_SCAN;
			target_q <= lls_pkg::TG_STOP;
			count_q <= '0;
			goal_q <= '0;
			pos_q <= '0;
			code_q <= '0;
		end else begin
			state_q <= state_d;
			target_q <= target_d;
			count_q <= count_d;
			goal_q <= goal_d;
			pos_q <= cmd_position;
			code_q <= cmd_code;
		end
	end

endmodule
`default_nettype wire

[rtl/lin_lift_motion_scheduler_top.sv]
// Results: a slot tick request accepted into the input register moves on to the
// result register, where out_valid offers it; a waiting result can hold it in between.
// Throughput: one request per clock while out_ready is high; a waiting result
// holds the input only once the input register also holds a slot tick.
// Set-target requests give no result and never wait on the result register.
// Reset (arst_n low) clears the slot index, motion state and target and loads
// the default register values.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lift motion scheduler top level
// Bus master schedule and motion command generator for a two-leg lift.
// ----------------------------------------------------------------------------
module lin_lift_motion_scheduler_top #(
	parameter int SLOTS_PER_CYCLE = lls_pkg::SLOTS_PER_CYCLE_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire lls_pkg::in_item_t         in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output lls_pkg::out_item_t             out_data,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [lls_pkg::CFG_W-1:0] cfg_wdata
);

	logic                         valid_s1;
	lls_pkg::in_item_t            data_s1;
	logic                         valid_s2;
	lls_pkg::out_item_t           data_s2;
	logic                         advance;
	logic                         tick;
	logic [lls_pkg::MARGIN_W-1:0] goal_offset_q;
	logic [lls_pkg::DCYC_W-1:0]   decel_cycles_q;
	lls_pkg::slot_info_t          info;
	lls_pkg::motion_ctl_t         mctl;
	logic [lls_pkg::POS_W-1:0]    cmd_position;
	logic [7:0]                   cmd_code;

	// A set-target request never needs the result register.
	assign advance = valid_s1 && ((data_s1.action == lls_pkg::ACT_SET_TARGET)
		|| !valid_s2 || out_ready);
	assign tick = advance && (data_s1.action == lls_pkg::ACT_TICK);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_offset_q <= lls_pkg::GOAL_OFFSET_RST;
			decel_cycles_q <= lls_pkg::DECEL_CYCLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lls_pkg::CFG_GOAL_OFFSET: goal_offset_q <= cfg_wdata;
				lls_pkg::CFG_DECEL_CYCLES: decel_cycles_q <= cfg_wdata[lls_pkg::DCYC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	lls_slot_sched #(
		.SLOTS_PER_CYCLE(SLOTS_PER_CYCLE)
	) u_slot_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.bus_busy (data_s1.bus_busy),
		.info     (info)
	);

	always_comb begin
		mctl.set_target = advance && (data_s1.action == lls_pkg::ACT_SET_TARGET);
		mctl.cmd_slot = info.cmd_slot;
		mctl.end_cycle = info.end_cycle;
	end

	lls_motion u_motion (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (mctl),
		.target_request (data_s1.target_request),
		.leg_a_position (data_s1.leg_a_position),
		.leg_b_position (data_s1.leg_b_position),
		.goal_offset    (goal_offset_q),
		.decel_cycles   (decel_cycles_q),
		.cmd_position   (cmd_position),
		.cmd_code       (cmd_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (tick) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			data_s2.frame_start <= info.frame_start;
			data_s2.frame_id <= info.frame_id;
			data_s2.byte_count <= info.byte_count;
			data_s2.is_transmit <= info.is_transmit;
			data_s2.abort_frame <= info.abort_frame;
			data_s2.payload_position <= info.cmd_slot ? cmd_position : '0;
			data_s2.payload_command <= info.cmd_slot ? cmd_code : '0;
			data_s2.report_valid <= info.end_cycle;
			data_s2.reported_position <= info.end_cycle ? cmd_position : '0;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

`ifndef ASSERT_OFF
	a_report_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_s2.report_valid) |-> !data_s2.frame_start)
		else $error("report given in a slot that starts a frame");

	a_command_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_s2.payload_command != 8'd0) |->
		(data_s2.frame_id == lls_pkg::ID_COMMAND && data_s2.is_transmit))
		else $error("command payload outside the command frame");

	a_tick_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && valid_s2) |-> out_ready)
		else $error("result register overwritten before it was taken");
`endif

endmodule
`default_nettype wire
